/* sv/sbnsod_pkg.sv */
// shared types and constants for the slot buffer (serve newest, drop oldest)
// no dependencies; used by the controller, the datapath and the top level
package sbnsod_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // operation codes carried in the input tuser
  localparam logic [1:0] KIND_PUT      = 2'd0;
  localparam logic [1:0] KIND_POP_NEW  = 2'd1;
  localparam logic [1:0] KIND_POP_OLD  = 2'd2;

  // result status codes carried in the output tuser
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_PUT_FULL   = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // capture the request and restart the scan
    logic scan;     // read the slot at the scan index and advance
    logic commit;   // update the slots and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // scan index is at the last slot
    logic out_busy;   // result register holds a result not yet taken
  } stat_t;

endpackage

/* sv/sbnsod_ctrl.sv */
// controller state machine for the slot buffer
// depends on sbnsod_pkg; drives the datapath through cmd_t, reads stat_t
module sbnsod_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  sbnsod_pkg::stat_t   stat,
  output sbnsod_pkg::cmd_t    cmd
);
  import sbnsod_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // last read slot is compared here
      S_DRAIN: begin
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/sbnsod_dp.sv */
// datapath for the slot buffer: slot storage, scan compare, result register
// depends on sbnsod_pkg; controlled by sbnsod_ctrl through cmd_t
module sbnsod_dp (
  input  logic               clk,
  input  logic               rst,
  input  sbnsod_pkg::cmd_t   cmd,
  output sbnsod_pkg::stat_t  stat,
  input  logic [63:0]        s_tdata,
  input  logic [1:0]         s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [71:0]        m_tdata,
  output logic [1:0]         m_tuser
);
  import sbnsod_pkg::*;

  // slot storage
  logic [31:0]      mem_time [SLOTS];
  logic [31:0]      mem_tag  [SLOTS];
  logic [SLOTS-1:0] used;
  logic [CNT_W-1:0] count;

  // captured request
  logic [1:0]       op_kind;
  logic [31:0]      op_time;
  logic [31:0]      op_tag;

  // scan pipeline
  logic [IDX_W-1:0] scan_idx;
  logic             rd_vld;
  logic             rd_used;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_time;
  logic [31:0]      rd_tag;

  // best candidate so far
  logic             best_valid;
  logic [IDX_W-1:0] best_idx;
  logic [31:0]      best_time;
  logic [31:0]      best_tag;
  logic             better;

  // lowest free slot
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // result register
  logic [1:0]       out_status;
  logic             out_pv;
  logic [31:0]      out_time;
  logic [31:0]      out_tag;
  logic             out_full;
  logic             out_empty;

  logic [1:0]       res_status;
  logic             res_pv;
  logic [31:0]      res_time;
  logic [31:0]      res_tag;
  logic [CNT_W-1:0] count_next;
  logic [SLOTS-1:0] used_next;
  logic             do_write;

  assign stat.scan_last = (scan_idx == IDX_W'(SLOTS - 1));
  assign stat.out_busy  = m_tvalid && !m_tready;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (op_kind == KIND_POP_NEW) begin
      better = rd_time > best_time;
    end else begin
      better = rd_time < best_time;
    end
  end

  // result and next state of the slots for the captured request
  always_comb begin
    res_status = ST_OK;
    res_pv     = 1'b0;
    res_time   = '0;
    res_tag    = '0;
    count_next = count;
    used_next  = used;
    do_write   = 1'b0;
    case (op_kind)
      KIND_PUT: begin
        if (free_found) begin
          do_write            = 1'b1;
          used_next[free_idx] = 1'b1;
          count_next          = count + CNT_W'(1);
        end else begin
          res_status = ST_PUT_FULL;
        end
      end
      KIND_POP_NEW, KIND_POP_OLD: begin
        if (best_valid) begin
          res_pv              = 1'b1;
          res_time            = best_time;
          res_tag             = best_tag;
          used_next[best_idx] = 1'b0;
          count_next          = count - CNT_W'(1);
        end else begin
          res_status = ST_POP_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // slot arrays: one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.commit && do_write) begin
      mem_time[free_idx] <= op_time;
      mem_tag[free_idx]  <= op_tag;
    end
    if (cmd.scan) begin
      rd_time <= mem_time[scan_idx];
      rd_tag  <= mem_tag[scan_idx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_kind <= s_tuser;
      op_time <= s_tdata[31:0];
      op_tag  <= s_tdata[63:32];
    end
    if (cmd.scan) begin
      rd_used <= used[scan_idx];
      rd_idx  <= scan_idx;
    end
    if (rd_vld && rd_used && (!best_valid || better)) begin
      best_idx  <= rd_idx;
      best_time <= rd_time;
      best_tag  <= rd_tag;
    end
    if (cmd.commit) begin
      out_status <= res_status;
      out_pv     <= res_pv;
      out_time   <= res_time;
      out_tag    <= res_tag;
      out_full   <= (count_next == CNT_W'(SLOTS));
      out_empty  <= (count_next == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      count      <= '0;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      best_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      if (cmd.accept) begin
        scan_idx   <= '0;
        best_valid <= 1'b0;
      end else if (cmd.scan) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (rd_vld && rd_used) begin
        best_valid <= 1'b1;
      end
      if (cmd.commit) begin
        used     <= used_next;
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {5'b0, out_empty, out_full, out_tag, out_time, out_pv};

endmodule

/* sv/slot_buffer_newest_serve_oldest_drop.sv */
// top level of the slot buffer that serves the newest and drops the oldest
// depends on sbnsod_pkg, sbnsod_ctrl and sbnsod_dp
//
// The buffer keeps up to SLOTS (8) requests, each a 32-bit arrival time and
// a 32-bit tag. A put (kind 0) stores into the lowest free slot, or is
// dropped with status 1 when all slots are used. A serve pop (kind 1) takes
// the request with the latest time, a deny pop (kind 2) the one with the
// earliest time; ties go to the lowest slot, and a pop on an empty buffer
// returns status 2. Kind 3 does nothing. Each request yields exactly one
// result carrying the removed request (zeros if none) and the full and empty
// flags after the operation. One request is handled at a time: a new request
// is accepted only after the previous one has committed. The scan reads one
// slot per cycle from the slot memory; then a drain state does the last
// compare and a commit state updates the slots and loads the result
// register. The result sits in an output register, so the next request is
// taken while it waits; that request then holds in its commit state until
// the output frees.
module slot_buffer_newest_serve_oldest_drop (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // arrival_time [31:0], request_tag [63:32]
  input  logic [1:0]  s_tuser,   // kind [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // popped_valid [0], popped_time [32:1],
                                 // popped_tag [64:33], is_full [65],
                                 // is_empty [66], zero [71:67]
  output logic [1:0]  m_tuser    // status [1:0]
);
  import sbnsod_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // sequencer: idle, scan all slots, drain the compare, commit
  sbnsod_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // slot storage, min / max search and the result register
  sbnsod_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
